>>> rtl/core/mexr_pkg.sv
`timescale 1ns / 1ps

package mexr_pkg;

	// Register map of the configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTIENT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd2;

	// Reset values of the configuration registers
	localparam int unsigned MODULUS_RESET  = 2;
	localparam int unsigned TOTIENT_RESET  = 1;
	localparam int unsigned EXPONENT_RESET = 0;

	// Trial division constants: 3 first, then 6k-1 / 6k+1 starting at 5
	localparam int unsigned SMALL_PRIME = 3;
	localparam int unsigned TRIAL_FIRST = 5;
	localparam int unsigned TRIAL_STEP  = 6;
	localparam int unsigned TRIAL_PAIR  = 2;
	localparam int unsigned MIN_MODULUS = 2;

	// Divider operand selection
	typedef enum logic [2:0] {
		DSEL_THREE,
		DSEL_TRIAL,
		DSEL_TRIAL_PAIR,
		DSEL_EXPONENT,
		DSEL_BASE
	} div_sel_t;

	// Modular multiplier operand selection
	typedef enum logic {
		MSEL_RESULT,
		MSEL_SQUARE
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_P_START,
		S_P_W3,
		S_P_LOOP,
		S_P_WA,
		S_P_LB,
		S_P_WB,
		S_E_RED,
		S_E_WAIT,
		S_B_RED,
		S_B_WAIT,
		S_LOOP,
		S_M_WR,
		S_M_SQ,
		S_M_WS,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     trial_init;
		logic     trial_step;
		logic     prime_set;
		logic     prime_val;
		logic     load_e_direct;
		logic     load_e_rem;
		logic     load_b_rem;
		logic     load_res_mul;
		logic     load_b_mul;
		logic     load_res_zero;
		logic     load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic n_le3;
		logic n_even;
		logic prime_valid;
		logic prime;
		logic totient_zero;
		logic sq_gt_n;
		logic div_done;
		logic rem_zero;
		logic mul_done;
		logic e_zero;
		logic e_lsb;
	} ctrl_status_t;

endpackage

>>> rtl/core/mexr_div.sv
`timescale 1ns / 1ps

module mexr_div #(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH:0]   dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] remainder,
	output logic             done
);

	localparam int unsigned CW = $clog2(WIDTH + 2);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH:0]   num_q;
	logic [WIDTH-1:0] den_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic [WIDTH:0]   rem_next;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign trial    = {rem_q, num_q[WIDTH]};
	assign diff     = trial - {1'b0, den_q};
	assign rem_next = (trial >= {1'b0, den_q}) ? diff : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[WIDTH-1:0], 1'b0};
			rem_q <= rem_next[WIDTH-1:0];
		end
	end

	assign remainder = rem_q;
	assign done      = done_q;

endmodule

>>> rtl/core/mexr_mulmod.sv
`timescale 1ns / 1ps

module mexr_mulmod #(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] op_a,
	input  logic [WIDTH-1:0] op_b,
	input  logic [WIDTH-1:0] modulus,
	output logic [WIDTH-1:0] product,
	output logic             done
);

	localparam int unsigned CW = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH+1:0] t;
	logic [WIDTH+1:0] n1;
	logic [WIDTH+1:0] n2;
	logic [WIDTH+1:0] r_next;

	// Double-and-add, MSB first: t = 2r + bit*a stays below 3n
	assign n1 = {2'b00, modulus};
	assign n2 = {1'b0, modulus, 1'b0};
	assign t  = {1'b0, r_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);

	always_comb begin
		if (t >= n2) begin
			r_next = t - n2;
		end else if (t >= n1) begin
			r_next = t - n1;
		end else begin
			r_next = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[WIDTH-2:0], 1'b0};
			r_q <= r_next[WIDTH-1:0];
		end
	end

	assign product = r_q;
	assign done    = done_q;

endmodule

>>> rtl/core/mexr_datapath.sv
`timescale 1ns / 1ps

module mexr_datapath #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [mexr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [WIDTH-1:0]                    cfg_data,
	input  logic [WIDTH:0]                      base_value,
	input  mexr_pkg::ctrl_cmd_t                 cmd,
	output mexr_pkg::ctrl_status_t              status,
	output logic [WIDTH-1:0]                    power_residue
);

	localparam int unsigned DW = WIDTH / 2 + 3;
	localparam int unsigned SW = WIDTH + 2;

	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] totient_q;
	logic [WIDTH-1:0] exponent_q;
	logic             prime_valid_q;
	logic             prime_q;
	logic [WIDTH:0]   base_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] res_q;
	logic [WIDTH-1:0] out_q;
	logic [DW-1:0]    d_q;
	logic [SW-1:0]    sq_q;

	logic [WIDTH:0]   magnitude;
	logic [DW-1:0]    d_pair;
	logic [WIDTH:0]   div_dividend;
	logic [WIDTH-1:0] div_divisor;
	logic [WIDTH-1:0] div_rem;
	logic             div_done;
	logic [WIDTH-1:0] mul_a;
	logic [WIDTH-1:0] mul_b;
	logic [WIDTH-1:0] mul_prod;
	logic             mul_done;

	// Configuration registers; a modulus write drops the cached primality
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= WIDTH'(mexr_pkg::MODULUS_RESET);
			totient_q     <= WIDTH'(mexr_pkg::TOTIENT_RESET);
			exponent_q    <= WIDTH'(mexr_pkg::EXPONENT_RESET);
			prime_valid_q <= 1'b0;
			prime_q       <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					mexr_pkg::REG_MODULUS: begin
						modulus_q     <= cfg_data;
						prime_valid_q <= 1'b0;
					end
					mexr_pkg::REG_TOTIENT:  totient_q  <= cfg_data;
					mexr_pkg::REG_EXPONENT: exponent_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.prime_set) begin
				prime_valid_q <= 1'b1;
				prime_q       <= cmd.prime_val;
			end
		end
	end

	assign magnitude = base_q[WIDTH] ? (~base_q + 1'b1) : base_q;
	assign d_pair    = d_q + DW'(mexr_pkg::TRIAL_PAIR);

	// Select divider operands
	always_comb begin
		case (cmd.div_sel)
			mexr_pkg::DSEL_THREE: begin
				div_dividend = {1'b0, modulus_q};
				div_divisor  = WIDTH'(mexr_pkg::SMALL_PRIME);
			end
			mexr_pkg::DSEL_TRIAL: begin
				div_dividend = {1'b0, modulus_q};
				div_divisor  = {{(WIDTH-DW){1'b0}}, d_q};
			end
			mexr_pkg::DSEL_TRIAL_PAIR: begin
				div_dividend = {1'b0, modulus_q};
				div_divisor  = {{(WIDTH-DW){1'b0}}, d_pair};
			end
			mexr_pkg::DSEL_EXPONENT: begin
				div_dividend = {1'b0, exponent_q};
				div_divisor  = prime_q ? (modulus_q - 1'b1) : totient_q;
			end
			mexr_pkg::DSEL_BASE: begin
				div_dividend = magnitude;
				div_divisor  = modulus_q;
			end
			default: begin
				div_dividend = {1'b0, modulus_q};
				div_divisor  = modulus_q;
			end
		endcase
	end

	assign mul_a = (cmd.mul_sel == mexr_pkg::MSEL_RESULT) ? res_q : b_q;
	assign mul_b = b_q;

	mexr_div #(.WIDTH(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.remainder (div_rem),
		.done      (div_done)
	);

	mexr_mulmod #(.WIDTH(WIDTH)) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.modulus (modulus_q),
		.product (mul_prod),
		.done    (mul_done)
	);

	// Working registers of one transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			base_q <= base_value;
		end
		if (cmd.trial_init) begin
			d_q  <= DW'(mexr_pkg::TRIAL_FIRST);
			sq_q <= SW'(mexr_pkg::TRIAL_FIRST * mexr_pkg::TRIAL_FIRST);
		end else if (cmd.trial_step) begin
			d_q  <= d_q + DW'(mexr_pkg::TRIAL_STEP);
			sq_q <= sq_q + SW'(d_q) * SW'(2 * mexr_pkg::TRIAL_STEP)
				+ SW'(mexr_pkg::TRIAL_STEP * mexr_pkg::TRIAL_STEP);
		end
		if (cmd.load_e_direct) begin
			e_q <= exponent_q;
		end else if (cmd.load_e_rem) begin
			e_q <= div_rem;
		end else if (cmd.load_b_mul) begin
			e_q <= {1'b0, e_q[WIDTH-1:1]};
		end
		if (cmd.load_b_rem) begin
			b_q <= (base_q[WIDTH] && div_rem != '0) ? (modulus_q - div_rem) : div_rem;
		end else if (cmd.load_b_mul) begin
			b_q <= mul_prod;
		end
		if (cmd.load_b_rem) begin
			res_q <= WIDTH'(1);
		end else if (cmd.load_res_mul) begin
			res_q <= mul_prod;
		end else if (cmd.load_res_zero) begin
			res_q <= '0;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign status.n_lt2        = modulus_q < WIDTH'(mexr_pkg::MIN_MODULUS);
	assign status.n_le3        = modulus_q <= WIDTH'(mexr_pkg::SMALL_PRIME);
	assign status.n_even       = ~modulus_q[0];
	assign status.prime_valid  = prime_valid_q;
	assign status.prime        = prime_q;
	assign status.totient_zero = totient_q == '0;
	assign status.sq_gt_n      = sq_q > {2'b00, modulus_q};
	assign status.div_done     = div_done;
	assign status.rem_zero     = div_rem == '0;
	assign status.mul_done     = mul_done;
	assign status.e_zero       = e_q == '0;
	assign status.e_lsb        = e_q[0];

	assign power_residue = out_q;

endmodule

>>> rtl/core/mexr_ctrl.sv
`timescale 1ns / 1ps

module mexr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  mexr_pkg::ctrl_status_t status,
	output mexr_pkg::ctrl_cmd_t    cmd
);

	mexr_pkg::state_t state_q;
	mexr_pkg::state_t state_next;
	logic             out_valid_q;
	logic             accept;
	logic             slot_free;

	assign in_ready  = (state_q == mexr_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			mexr_pkg::S_IDLE: begin
				if (accept) begin
					if (status.n_lt2) state_next = mexr_pkg::S_FIN;
					else if (status.prime_valid) state_next = mexr_pkg::S_E_RED;
					else state_next = mexr_pkg::S_P_START;
				end
			end
			mexr_pkg::S_P_START: begin
				if (status.n_le3 || status.n_even) state_next = mexr_pkg::S_E_RED;
				else state_next = mexr_pkg::S_P_W3;
			end
			mexr_pkg::S_P_W3: begin
				if (status.div_done) begin
					state_next = status.rem_zero ? mexr_pkg::S_E_RED : mexr_pkg::S_P_LOOP;
				end
			end
			mexr_pkg::S_P_LOOP: begin
				state_next = status.sq_gt_n ? mexr_pkg::S_E_RED : mexr_pkg::S_P_WA;
			end
			mexr_pkg::S_P_WA: begin
				if (status.div_done) begin
					state_next = status.rem_zero ? mexr_pkg::S_E_RED : mexr_pkg::S_P_LB;
				end
			end
			mexr_pkg::S_P_LB: state_next = mexr_pkg::S_P_WB;
			mexr_pkg::S_P_WB: begin
				if (status.div_done) begin
					state_next = status.rem_zero ? mexr_pkg::S_E_RED : mexr_pkg::S_P_LOOP;
				end
			end
			mexr_pkg::S_E_RED: begin
				if (!status.prime && status.totient_zero) state_next = mexr_pkg::S_B_RED;
				else state_next = mexr_pkg::S_E_WAIT;
			end
			mexr_pkg::S_E_WAIT: if (status.div_done) state_next = mexr_pkg::S_B_RED;
			mexr_pkg::S_B_RED: state_next = mexr_pkg::S_B_WAIT;
			mexr_pkg::S_B_WAIT: if (status.div_done) state_next = mexr_pkg::S_LOOP;
			mexr_pkg::S_LOOP: begin
				if (status.e_zero) state_next = mexr_pkg::S_FIN;
				else if (status.e_lsb) state_next = mexr_pkg::S_M_WR;
				else state_next = mexr_pkg::S_M_SQ;
			end
			mexr_pkg::S_M_WR: if (status.mul_done) state_next = mexr_pkg::S_M_SQ;
			mexr_pkg::S_M_SQ: state_next = mexr_pkg::S_M_WS;
			mexr_pkg::S_M_WS: if (status.mul_done) state_next = mexr_pkg::S_LOOP;
			mexr_pkg::S_FIN: if (slot_free) state_next = mexr_pkg::S_IDLE;
			default: state_next = mexr_pkg::S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd         = '0;
		cmd.div_sel = mexr_pkg::DSEL_THREE;
		cmd.mul_sel = mexr_pkg::MSEL_RESULT;
		case (state_q)
			mexr_pkg::S_IDLE: begin
				cmd.capture       = accept;
				cmd.load_res_zero = accept && status.n_lt2;
			end
			mexr_pkg::S_P_START: begin
				if (status.n_le3) begin
					cmd.prime_set = 1'b1;
					cmd.prime_val = 1'b1;
				end else if (status.n_even) begin
					cmd.prime_set = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			mexr_pkg::S_P_W3: begin
				cmd.div_sel    = mexr_pkg::DSEL_THREE;
				cmd.prime_set  = status.div_done && status.rem_zero;
				cmd.trial_init = status.div_done && !status.rem_zero;
			end
			mexr_pkg::S_P_LOOP: begin
				cmd.div_sel = mexr_pkg::DSEL_TRIAL;
				if (status.sq_gt_n) begin
					cmd.prime_set = 1'b1;
					cmd.prime_val = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			mexr_pkg::S_P_WA: begin
				cmd.div_sel   = mexr_pkg::DSEL_TRIAL;
				cmd.prime_set = status.div_done && status.rem_zero;
			end
			mexr_pkg::S_P_LB: begin
				cmd.div_sel   = mexr_pkg::DSEL_TRIAL_PAIR;
				cmd.div_start = 1'b1;
			end
			mexr_pkg::S_P_WB: begin
				cmd.div_sel    = mexr_pkg::DSEL_TRIAL_PAIR;
				cmd.prime_set  = status.div_done && status.rem_zero;
				cmd.trial_step = status.div_done && !status.rem_zero;
			end
			mexr_pkg::S_E_RED: begin
				cmd.div_sel = mexr_pkg::DSEL_EXPONENT;
				if (!status.prime && status.totient_zero) cmd.load_e_direct = 1'b1;
				else cmd.div_start = 1'b1;
			end
			mexr_pkg::S_E_WAIT: begin
				cmd.div_sel    = mexr_pkg::DSEL_EXPONENT;
				cmd.load_e_rem = status.div_done;
			end
			mexr_pkg::S_B_RED: begin
				cmd.div_sel   = mexr_pkg::DSEL_BASE;
				cmd.div_start = 1'b1;
			end
			mexr_pkg::S_B_WAIT: begin
				cmd.div_sel    = mexr_pkg::DSEL_BASE;
				cmd.load_b_rem = status.div_done;
			end
			mexr_pkg::S_LOOP: begin
				cmd.mul_sel   = mexr_pkg::MSEL_RESULT;
				cmd.mul_start = !status.e_zero && status.e_lsb;
			end
			mexr_pkg::S_M_WR: begin
				cmd.mul_sel      = mexr_pkg::MSEL_RESULT;
				cmd.load_res_mul = status.mul_done;
			end
			mexr_pkg::S_M_SQ: begin
				cmd.mul_sel   = mexr_pkg::MSEL_SQUARE;
				cmd.mul_start = 1'b1;
			end
			mexr_pkg::S_M_WS: begin
				cmd.mul_sel    = mexr_pkg::MSEL_SQUARE;
				cmd.load_b_mul = status.mul_done;
			end
			mexr_pkg::S_FIN: cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			// Hold the result until the transaction completes
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_start && cmd.mul_start))
		else $error("divider and multiplier started together");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == mexr_pkg::S_P_W3 || state_q == mexr_pkg::S_P_WA
			|| state_q == mexr_pkg::S_P_WB || state_q == mexr_pkg::S_E_WAIT
			|| state_q == mexr_pkg::S_B_WAIT))
		else $error("divider finished outside a wait state");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> (state_q == mexr_pkg::S_M_WR || state_q == mexr_pkg::S_M_WS))
		else $error("multiplier finished outside a wait state");

endmodule

>>> rtl/core/modular_exponentiation_reduced_core.sv
`timescale 1ns / 1ps

// Computes base^e mod modulus for each signed base, one transaction at a time. The exponent
// is first reduced modulo (modulus - 1) when the modulus is prime, otherwise modulo the
// totient (unreduced if the totient is zero); a modulus below two answers 0. One shared
// bit-serial divider, used for the exponent and base reductions and for trial division, and
// one bit-serial modular multiplier do the work: the two reductions are followed by up to
// WIDTH rounds of one or two products. Primality of the modulus is found by trial division
// on the first transaction after reset or after the modulus is written, and then cached.
module modular_exponentiation_reduced_core #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [mexr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [WIDTH-1:0]                 cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [WIDTH:0]            base_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [WIDTH-1:0]                 power_residue
);

	mexr_pkg::ctrl_cmd_t    cmd;
	mexr_pkg::ctrl_status_t status;

	mexr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mexr_datapath #(.WIDTH(WIDTH)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.base_value    (base_value),
		.cmd           (cmd),
		.status        (status),
		.power_residue (power_residue)
	);

endmodule
